// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// concurrent checks on clk_i, disabled while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_RST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_RST(lbl, prop, msg)
`define ASSERT_RST_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/pke_pkg.sv
// ---------------------------------------------------------------------------
// pke_pkg
// shared widths, codes and command/status types of the knee splitter
// ---------------------------------------------------------------------------
`default_nettype none
package pke_pkg;

  localparam int COORD_BITS = 16;
  localparam int TDATA_W    = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int THR_W      = 16;
  localparam logic [THR_W-1:0] THR_RESET = 16'hD99A;  // -9830

  localparam int SQ_W      = 2 * COORD_BITS;
  localparam int SUM_W     = SQ_W + 1;
  localparam int LEN_W     = 2 * SUM_W;
  localparam int TSQ_W     = 2 * THR_W;
  localparam int DIG_W     = 8;
  localparam int MB_RAW    = (SUM_W > TSQ_W) ? SUM_W : TSQ_W;
  localparam int MUL_B_W   = ((MB_RAW + DIG_W - 1) / DIG_W) * DIG_W;
  localparam int NDIG      = MUL_B_W / DIG_W;
  localparam int CNT_W     = $clog2(NDIG + 1);
  localparam int ACC_W     = LEN_W + TSQ_W;
  localparam int LHS_SHIFT = 28;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_DIFF,
    ST_SQR,
    ST_SUM,
    ST_LEN_GO,
    ST_LEN_W,
    ST_DM_GO,
    ST_DM_W,
    ST_RHS_GO,
    ST_RHS_W,
    ST_DEC,
    ST_EMIT_CUR,
    ST_EMIT_OPEN,
    ST_ADV,
    ST_EMIT_LAST
  } state_e;

  typedef enum logic [1:0] {
    MS_LEN,
    MS_DM,
    MS_RHS
  } mul_sel_e;

  typedef enum logic [1:0] {
    EM_NEW,
    EM_CUR_KNEE,
    EM_CUR_OPEN
  } emit_src_e;

  typedef struct packed {
    logic      load_in;
    logic      diff;
    logic      sqr;
    logic      sum;
    logic      mul_start;
    mul_sel_e  mul_sel;
    logic      decide;
    logic      emit;
    emit_src_e emit_src;
    logic      shift;
  } dp_cmd_t;

  typedef struct packed {
    logic nlast;
    logic knee;
    logic out_free;
    logic mul_done;
  } dp_status_t;

endpackage
`default_nettype wire

// File: rtl/polyline_knee_splitter_top.sv
// flow: a new point is taken only in the idle state, after the previous point has
//   been processed and its results loaded into the output register
// an interior point takes three passes through the shared 8-bit digit-serial
//   multiplier; the first and second points of a line do not use it
// reset: async active low, empties the point window, threshold back to -9830
// ---------------------------------------------------------------------------
// polyline_knee_splitter_top
// splits polylines at knees found by an exact half-cosine threshold test
// ---------------------------------------------------------------------------
`default_nettype none
module polyline_knee_splitter_top import pke_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [TDATA_W-1:0] s_axis_tdata,   // point_x, point_y
  input  wire logic               s_axis_tlast,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [TDATA_W-1:0]      m_axis_tdata,   // out_x, out_y
  output logic                    m_axis_tlast,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [THR_W-1:0]   cfg_data_i
);

  dp_cmd_t               cmd;
  dp_status_t            st;
  logic [COORD_BITS-1:0] out_x, out_y;

  pke_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .st_i       (st)
  );

  pke_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .in_x_i      (s_axis_tdata[COORD_BITS-1:0]),
    .in_y_i      (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .in_last_i   (s_axis_tlast),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_x_o     (out_x),
    .out_y_o     (out_y),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = TDATA_W'({out_y, out_x});
  assign cfg_ready_o  = 1'b1;

endmodule
`default_nettype wire

// File: rtl/pke_mul.sv
// ---------------------------------------------------------------------------
// pke_mul
// digit-serial multiplier, one 8-bit digit of b per cycle, msb digit first
// ---------------------------------------------------------------------------
`default_nettype none
module pke_mul import pke_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [LEN_W-1:0]   a_i,
  input  wire logic [MUL_B_W-1:0] b_i,
  output logic                    done_o,
  output logic [ACC_W-1:0]        prod_o
);

  logic [LEN_W-1:0]       a_q;
  logic [MUL_B_W-1:0]     b_q;
  logic [ACC_W-1:0]       acc_q, acc_d;
  logic [CNT_W-1:0]       cnt_q;
  logic                   done_q;
  logic [DIG_W-1:0]       digit;
  logic [LEN_W+DIG_W-1:0] part;

  assign digit = b_q[MUL_B_W-1 -: DIG_W];
  assign part  = (LEN_W + DIG_W)'(a_q) * (LEN_W + DIG_W)'(digit);
  assign acc_d = {acc_q[ACC_W-DIG_W-1:0], DIG_W'(0)} + ACC_W'(part);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CNT_W'(1));
      if (start_i) begin
        cnt_q <= CNT_W'(NDIG);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (cnt_q != '0) begin
      b_q   <= {b_q[MUL_B_W-DIG_W-1:0], DIG_W'(0)};
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule
`default_nettype wire

// File: rtl/pke_dp.sv
// ---------------------------------------------------------------------------
// pke_dp
// point window, knee arithmetic, threshold register and output register
// ---------------------------------------------------------------------------
`default_nettype none
module pke_dp import pke_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire dp_cmd_t               cmd_i,
  output dp_status_t                 st_o,
  input  wire logic [COORD_BITS-1:0] in_x_i,
  input  wire logic [COORD_BITS-1:0] in_y_i,
  input  wire logic                  in_last_i,
  input  wire logic                  cfg_valid_i,
  input  wire logic [THR_W-1:0]      cfg_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [COORD_BITS-1:0]      out_x_o,
  output logic [COORD_BITS-1:0]      out_y_o,
  output logic                       out_last_o
);

  function automatic logic [COORD_BITS:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                   input logic [COORD_BITS-1:0] b);
    logic [COORD_BITS:0] r;
    if (a < b) r = {1'b1, b - a};
    else       r = {1'b0, a - b};
    return r;
  endfunction

  logic [THR_W-1:0]      thr_q;
  logic [COORD_BITS-1:0] nx_q, ny_q, px_q, py_q, cx_q, cy_q;
  logic                  nlast_q;
  logic [COORD_BITS-1:0] ax_q, ay_q, bx_q, by_q;
  logic                  nax_q, nay_q, nbx_q, nby_q;
  logic [SQ_W-1:0]       axx_q, ayy_q, bxx_q, byy_q, p1_q, p2_q;
  logic [TSQ_W-1:0]      tsq_q;
  logic                  s1_q, s2_q;
  logic [SUM_W-1:0]      a2_q, b2_q, dm_q;
  logic                  dneg_q;
  logic [LEN_W-1:0]      len_q, dm2_q;
  logic [ACC_W-1:0]      rhs_q;
  logic                  knee_q;
  logic                  out_valid_q, out_last_q;
  logic [COORD_BITS-1:0] out_x_q, out_y_q;

  logic [COORD_BITS:0]   dax, day, dbx, dby;
  logic [THR_W-1:0]      tm;
  logic [SUM_W-1:0]      dm_d;
  logic                  dneg_d;
  logic [LEN_W-1:0]      mul_a;
  logic [MUL_B_W-1:0]    mul_b;
  logic                  mul_done;
  logic [ACC_W-1:0]      prod;
  logic [ACC_W-1:0]      lhs;
  logic                  dz, dn, knee_d;
  logic                  out_free;

  assign dax = abs_diff(px_q, cx_q);
  assign day = abs_diff(py_q, cy_q);
  assign dbx = abs_diff(nx_q, cx_q);
  assign dby = abs_diff(ny_q, cy_q);
  assign tm  = thr_q[THR_W-1] ? (~thr_q + THR_W'(1)) : thr_q;

  // signed-magnitude dot product
  always_comb begin
    if (s1_q == s2_q) begin
      dm_d   = SUM_W'(p1_q) + SUM_W'(p2_q);
      dneg_d = s1_q;
    end else if (p1_q >= p2_q) begin
      dm_d   = SUM_W'(p1_q - p2_q);
      dneg_d = s1_q;
    end else begin
      dm_d   = SUM_W'(p2_q - p1_q);
      dneg_d = s2_q;
    end
  end

  always_comb begin
    unique case (cmd_i.mul_sel)
      MS_LEN: begin
        mul_a = LEN_W'(a2_q);
        mul_b = MUL_B_W'(b2_q);
      end
      MS_DM: begin
        mul_a = LEN_W'(dm_q);
        mul_b = MUL_B_W'(dm_q);
      end
      MS_RHS: begin
        mul_a = len_q;
        mul_b = MUL_B_W'(tsq_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  pke_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  // exact compare of dot^2 * 2^28 against |a|^2 |b|^2 T^2
  assign lhs = ACC_W'(dm2_q) << LHS_SHIFT;
  assign dz  = (dm_q == '0);
  assign dn  = dneg_q & ~dz;

  always_comb begin
    priority if (a2_q == '0 || b2_q == '0) knee_d = 1'b0;
    else if (!dn && thr_q[THR_W-1])        knee_d = 1'b1;
    else if ((dn || dz) && !thr_q[THR_W-1]) knee_d = 1'b0;
    else if (!dn && thr_q == '0)           knee_d = 1'b1;
    else if (!dn)                          knee_d = (lhs > rhs_q);
    else                                   knee_d = (lhs < rhs_q);
  end

  assign out_free = ~out_valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= THR_RESET;
      px_q        <= '0;
      py_q        <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
      if (cmd_i.shift) begin
        px_q <= cx_q;
        py_q <= cy_q;
        cx_q <= nx_q;
        cy_q <= ny_q;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      nx_q    <= in_x_i;
      ny_q    <= in_y_i;
      nlast_q <= in_last_i;
    end
    if (cmd_i.diff) begin
      {nax_q, ax_q} <= dax;
      {nay_q, ay_q} <= day;
      {nbx_q, bx_q} <= dbx;
      {nby_q, by_q} <= dby;
    end
    if (cmd_i.sqr) begin
      axx_q <= SQ_W'(ax_q) * SQ_W'(ax_q);
      ayy_q <= SQ_W'(ay_q) * SQ_W'(ay_q);
      bxx_q <= SQ_W'(bx_q) * SQ_W'(bx_q);
      byy_q <= SQ_W'(by_q) * SQ_W'(by_q);
      p1_q  <= SQ_W'(ax_q) * SQ_W'(bx_q);
      p2_q  <= SQ_W'(ay_q) * SQ_W'(by_q);
      tsq_q <= TSQ_W'(tm) * TSQ_W'(tm);
      s1_q  <= nax_q ^ nbx_q;
      s2_q  <= nay_q ^ nby_q;
    end
    if (cmd_i.sum) begin
      a2_q   <= SUM_W'(axx_q) + SUM_W'(ayy_q);
      b2_q   <= SUM_W'(bxx_q) + SUM_W'(byy_q);
      dm_q   <= dm_d;
      dneg_q <= dneg_d;
    end
    if (mul_done) begin
      unique case (cmd_i.mul_sel)
        MS_LEN:  len_q <= prod[LEN_W-1:0];
        MS_DM:   dm2_q <= prod[LEN_W-1:0];
        MS_RHS:  rhs_q <= prod;
        default: rhs_q <= rhs_q;
      endcase
    end
    if (cmd_i.decide) begin
      knee_q <= knee_d;
    end
    if (cmd_i.emit) begin
      unique case (cmd_i.emit_src)
        EM_NEW: begin
          out_x_q    <= nx_q;
          out_y_q    <= ny_q;
          out_last_q <= nlast_q;
        end
        EM_CUR_KNEE: begin
          out_x_q    <= cx_q;
          out_y_q    <= cy_q;
          out_last_q <= knee_q;
        end
        EM_CUR_OPEN: begin
          out_x_q    <= cx_q;
          out_y_q    <= cy_q;
          out_last_q <= 1'b0;
        end
        default: begin
          out_x_q    <= cx_q;
          out_y_q    <= cy_q;
          out_last_q <= 1'b0;
        end
      endcase
    end
  end

  assign st_o.nlast    = nlast_q;
  assign st_o.knee     = knee_q;
  assign st_o.out_free = out_free;
  assign st_o.mul_done = mul_done;

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_last_o  = out_last_q;

endmodule
`default_nettype wire

// File: rtl/pke_ctrl.sv
// ---------------------------------------------------------------------------
// pke_ctrl
// sequencer: point window bookkeeping, knee computation steps, result order
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module pke_ctrl import pke_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output dp_cmd_t         cmd_o,
  input  wire dp_status_t st_i
);

  state_e     state_q, state_d;
  logic [1:0] held_q, held_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      held_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    held_d     = held_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          priority if (held_q == 2'd0) state_d = ST_FIRST;
          else if (held_q == 2'd1)     state_d = ST_ADV;
          else                         state_d = ST_DIFF;
        end
      end
      ST_FIRST: begin
        if (st_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_src = EM_NEW;
          cmd_o.shift    = 1'b1;
          held_d         = st_i.nlast ? 2'd0 : 2'd1;
          state_d        = ST_IDLE;
        end
      end
      ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = ST_SQR;
      end
      ST_SQR: begin
        cmd_o.sqr = 1'b1;
        state_d   = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_LEN_GO;
      end
      ST_LEN_GO: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MS_LEN;
        state_d         = ST_LEN_W;
      end
      ST_LEN_W: begin
        cmd_o.mul_sel = MS_LEN;
        if (st_i.mul_done) state_d = ST_DM_GO;
      end
      ST_DM_GO: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MS_DM;
        state_d         = ST_DM_W;
      end
      ST_DM_W: begin
        cmd_o.mul_sel = MS_DM;
        if (st_i.mul_done) state_d = ST_RHS_GO;
      end
      ST_RHS_GO: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MS_RHS;
        state_d         = ST_RHS_W;
      end
      ST_RHS_W: begin
        cmd_o.mul_sel = MS_RHS;
        if (st_i.mul_done) state_d = ST_DEC;
      end
      ST_DEC: begin
        cmd_o.decide = 1'b1;
        state_d      = ST_EMIT_CUR;
      end
      ST_EMIT_CUR: begin
        if (st_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_src = EM_CUR_KNEE;
          state_d        = st_i.knee ? ST_EMIT_OPEN : ST_ADV;
        end
      end
      ST_EMIT_OPEN: begin
        if (st_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_src = EM_CUR_OPEN;
          state_d        = ST_ADV;
        end
      end
      ST_ADV: begin
        cmd_o.shift = 1'b1;
        held_d      = 2'd2;
        state_d     = st_i.nlast ? ST_EMIT_LAST : ST_IDLE;
      end
      ST_EMIT_LAST: begin
        if (st_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_src = EM_NEW;
          held_d         = 2'd0;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `ASSERT_RST(a_held_range, held_q != 2'd3, "window count out of range")
  `ASSERT_RST(a_emit_free, cmd_o.emit |-> st_i.out_free, "result loaded into busy output")
  `ASSERT_RST(a_open_knee, (state_q == ST_EMIT_OPEN) |-> st_i.knee, "reopen without knee")
  `ASSERT_RST(a_done_wait, st_i.mul_done |-> (state_q == ST_LEN_W || state_q == ST_DM_W || state_q == ST_RHS_W), "product done outside wait state")
  `ASSERT_RST_NEXT(a_done_pulse, st_i.mul_done, !st_i.mul_done, "product done longer than one cycle")

endmodule
`default_nettype wire

// File: test/tb_polyline_knee_splitter_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_polyline_knee_splitter_top
// streams polylines into the knee splitter under random source bursts and
// sink stalls, predicts the emitted points with an exact half-cosine test,
// and compares every output point in order across several threshold settings
// ---------------------------------------------------------------------------
module tb_polyline_knee_splitter_top;
  import pke_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_POINTS   = 38;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct {
    coord_t x;
    coord_t y;
    bit     ends;
  } out_point_t;

  class knee_split_checker;
    out_point_t        expected_out[$];
    logic signed [THR_W-1:0] threshold;
    coord_t            prev_x, prev_y, cur_x, cur_y;
    int                held;
    int                errors, knees, matched;

    function new();
      threshold = THR_RESET;
      prev_x = '0; prev_y = '0; cur_x = '0; cur_y = '0;
      held = 0; errors = 0; knees = 0; matched = 0;
    endfunction

    function void set_threshold(logic [THR_W-1:0] value);
      threshold = value;
    endfunction

    function int pending();
      return expected_out.size();
    endfunction

    // exact test: dot / (2 |a| |b|) > thr / 2^15
    function bit is_knee(coord_t nx, coord_t ny);
      longint ax, ay, bx, by, a2, b2, dot;
      int thr, thr_mag;
      logic [127:0] mag, lhs, rhs;
      ax = longint'(prev_x) - longint'(cur_x);
      ay = longint'(prev_y) - longint'(cur_y);
      bx = longint'(nx) - longint'(cur_x);
      by = longint'(ny) - longint'(cur_y);
      a2 = ax * ax + ay * ay;
      b2 = bx * bx + by * by;
      if (a2 == 0 || b2 == 0) return 1'b0;
      dot = ax * bx + ay * by;
      thr = int'(threshold);
      if (thr < 0 && dot >= 0) return 1'b1;
      if (thr >= 0 && dot <= 0) return 1'b0;
      if (thr == 0) return 1'b1;
      thr_mag = (thr < 0) ? -thr : thr;
      mag = 128'((dot < 0) ? -dot : dot);
      lhs = (mag * mag) << LHS_SHIFT;
      rhs = 128'(a2) * 128'(b2) * 128'(thr_mag) * 128'(thr_mag);
      return (dot > 0) ? (lhs > rhs) : (lhs < rhs);
    endfunction

    function void push(coord_t x, coord_t y, bit ends);
      out_point_t p;
      p.x = x; p.y = y; p.ends = ends;
      expected_out.push_back(p);
    endfunction

    function void predict_point(coord_t x, coord_t y, bit last);
      bit knee;
      if (held == 0) begin
        push(x, y, last);
        cur_x = x; cur_y = y;
        held = last ? 0 : 1;
      end else begin
        if (held == 2) begin
          knee = is_knee(x, y);
          push(cur_x, cur_y, knee);
          if (knee) begin
            push(cur_x, cur_y, 1'b0);
            knees++;
          end
        end
        prev_x = cur_x; prev_y = cur_y;
        cur_x = x; cur_y = y;
        held = 2;
        if (last) begin
          push(x, y, 1'b1);
          held = 0;
        end
      end
    endfunction

    function void check_output(coord_t x, coord_t y, bit ends);
      out_point_t e;
      if (expected_out.size() == 0) begin
        $display("%0t: unexpected output point x=%h y=%h ends=%0d", $time, x, y, ends);
        errors++;
        return;
      end
      e = expected_out.pop_front();
      if (e.x !== x || e.y !== y || e.ends !== ends) begin
        $display("%0t: output mismatch, expected x=%h y=%h ends=%0d, got x=%h y=%h ends=%0d",
                 $time, e.x, e.y, e.ends, x, y, ends);
        errors++;
      end else begin
        matched++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata = '0;   // point_x, point_y
  logic               s_axis_tlast = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;        // out_x, out_y
  logic               m_axis_tlast;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [THR_W-1:0]   cfg_data_i = '0;

  knee_split_checker splitter_sb = new();
  int  burst_left = 0;
  int  points_sent = 0;
  int  settings_used = 1;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  sink_cycle = 0;
  int  idle_cycles = 0;

  polyline_knee_splitter_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // sink: rotating stall patterns, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case ((sink_cycle / 97) % 4)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 1) == 1);
        2: m_axis_tready <= (sink_cycle % 5) != 0;
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
    sink_cycle++;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      splitter_sb.check_output(m_axis_tdata[COORD_BITS-1:0],
                               m_axis_tdata[2*COORD_BITS-1:COORD_BITS], m_axis_tlast);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d output points outstanding",
               $time, WATCHDOG_LIMIT, splitter_sb.pending());
      $display("polyline_knee_splitter_top test failed");
      $finish;
    end
  end

  task automatic send_point(coord_t x, coord_t y, bit last);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    splitter_sb.predict_point(x, y, last);
    points_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (splitter_sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    splitter_sb.set_threshold(value);
    settings_used++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic step_coord(inout coord_t c);
    case ($urandom_range(0, 9))
      0: c = coord_t'($urandom);
      1: c = c;
      2, 3: c = c + coord_t'($urandom_range(0, 8000)) - coord_t'(4000);
      default: c = c + coord_t'($urandom_range(0, 80)) - coord_t'(40);
    endcase
  endtask

  task automatic run_random_lines(int n_points);
    int sent, len, pick;
    coord_t x, y;
    sent = 0;
    while (sent < n_points) begin
      pick = $urandom_range(0, 9);
      len = (pick == 0) ? 1 : (pick == 1) ? 2 : $urandom_range(3, 10);
      x = coord_t'($urandom);
      y = coord_t'($urandom);
      for (int k = 0; k < len; k++) begin
        if (k > 0) begin
          // repeated point now and then for zero-length vectors
          if ($urandom_range(0, 11) == 0) begin
            x = x; y = y;
          end else begin
            step_coord(x);
            step_coord(y);
          end
        end
        send_point(x, y, k == len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    logic [THR_W-1:0] phase_thr [7];
    phase_thr[0] = 16'h7FFF;
    phase_thr[1] = 16'h8000;
    phase_thr[2] = 16'h0000;
    phase_thr[3] = THR_W'($urandom);
    phase_thr[4] = 16'h4000;
    phase_thr[5] = 16'hC000;
    phase_thr[6] = THR_W'($urandom);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // single-point lines at both coordinate extremes
    send_point(16'h0000, 16'h0000, 1'b1);
    send_point(16'hFFFF, 16'hFFFF, 1'b1);
    // two-point line
    send_point(16'h1234, 16'h5678, 1'b0);
    send_point(16'hFFFF, 16'h0000, 1'b1);
    // straight line, no knee
    send_point(16'd0, 16'd0, 1'b0);
    send_point(16'd16, 16'd0, 1'b0);
    send_point(16'd32, 16'd0, 1'b1);
    // right angle
    send_point(16'd100, 16'd100, 1'b0);
    send_point(16'd200, 16'd100, 1'b0);
    send_point(16'd200, 16'd200, 1'b1);
    // full reversal across the whole range
    send_point(16'h0000, 16'h0000, 1'b0);
    send_point(16'hFFFF, 16'hFFFF, 1'b0);
    send_point(16'h0000, 16'h0000, 1'b1);
    // repeated point, zero-length vector on the near side
    send_point(16'd50, 16'd50, 1'b0);
    send_point(16'd50, 16'd50, 1'b0);
    send_point(16'd80, 16'd90, 1'b1);
    // repeated point in the middle of a line
    send_point(16'd10, 16'd10, 1'b0);
    send_point(16'd20, 16'd20, 1'b0);
    send_point(16'd20, 16'd20, 1'b0);
    send_point(16'd5, 16'd30, 1'b1);
    // square walked around the corners
    send_point(16'h0000, 16'h0000, 1'b0);
    send_point(16'hFFFF, 16'h0000, 1'b0);
    send_point(16'hFFFF, 16'hFFFF, 1'b0);
    send_point(16'h0000, 16'hFFFF, 1'b0);
    send_point(16'h0000, 16'h0000, 1'b1);
    wait_drained();

    for (int p = 0; p < 7; p++) begin
      if (p == 2) hold_req = 1'b1;
      write_threshold(phase_thr[p]);
      run_random_lines(PHASE_POINTS);
      wait_drained();
    end

    $display("sent %0d points over %0d threshold settings (both extremes included)",
             points_sent, settings_used);
    $display("checked %0d output points, %0d knees split", splitter_sb.matched,
             splitter_sb.knees);
    if (splitter_sb.errors == 0) begin
      $display("polyline_knee_splitter_top test passed");
    end else begin
      $display("polyline_knee_splitter_top test failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/pke_pkg.sv
rtl/pke_mul.sv
rtl/pke_dp.sv
rtl/pke_ctrl.sv
rtl/polyline_knee_splitter_top.sv
test/tb_polyline_knee_splitter_top.sv
